[rtl/twtt_pkg.sv]
package twtt_pkg;

  localparam int unsigned BUCKET_COUNT_DEF = 4096;
  localparam int unsigned VAL_W = 12;

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef logic signed [VAL_W-1:0] repl_val_t;

  localparam repl_val_t REPL_MIN = -12'sd2;

  typedef struct packed {
    logic              kind;
    logic [63:0]       position_key;
    logic signed [15:0] search_score;
    logic [15:0]       best_move;
    logic signed [15:0] static_eval;
    logic [7:0]        search_depth;
    logic [1:0]        bound_type;
  } in_beat_t;

  typedef struct packed {
    logic              hit;
    logic              written;
    logic signed [15:0] found_score;
    logic [15:0]       found_move;
    logic signed [15:0] found_eval;
    logic [7:0]        found_depth;
    logic [1:0]        found_bound;
    logic [5:0]        found_age;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] score;
    logic [15:0] move;
    logic [15:0] eval;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic [5:0]  age;
  } entry_t;

  typedef struct packed {
    entry_t slot2;
    entry_t slot1;
  } bucket_t;

  typedef struct packed {
    logic      match;
    repl_val_t value;
  } slot_res_t;

endpackage

[rtl/twtt_bucket_ram.sv]
module twtt_bucket_ram import twtt_pkg::*; #(
  parameter int unsigned DEPTH = BUCKET_COUNT_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  bucket_t           wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output bucket_t           rdata_o
);

  bucket_t mem [DEPTH];
  bucket_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/twtt_slot_eval.sv]
module twtt_slot_eval import twtt_pkg::*; (
  input  entry_t      slot_i,
  input  logic [63:0] key_i,
  input  logic [7:0]  depth_i,
  input  logic [5:0]  age_i,
  output slot_res_t   res_o
);

  logic [5:0] age_diff;

  assign age_diff = age_i - slot_i.age;

  // 16 * age gap + new depth - stored depth
  assign res_o.match = (slot_i.key == key_i);
  assign res_o.value = $signed({2'b00, age_diff, 4'b0000})
                     + $signed({4'b0000, depth_i})
                     - $signed({4'b0000, slot_i.depth});

endmodule

[rtl/two_way_transposition_table.sv]
// channel   | signals                                   | beat
// input     | in_valid_i / in_ready_o / in_data_i       | probe or store request
// output    | out_valid_o / out_ready_i / out_data_o    | one result per request
// config    | psel penable pwrite paddr pwdata prdata   | current_age at address 0
// after reset the bucket ram is zeroed, one bucket a cycle, no input taken
// each request steps from accept to a registered result: accept, slot 1, slot 2, resolve
// one slot evaluator is shared by both slots and the bucket ram has one read and one write port
// a result waiting on out_ready_i holds the resolve step; the next beat is taken once it is loaded
module two_way_transposition_table import twtt_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(BUCKET_COUNT - 1);
  localparam logic ADDR_AGE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT1,
    ST_SLOT2,
    ST_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [5:0] age_q, age_d;
  in_beat_t   item_q, item_d;
  slot_res_t  s1_q, s1_d;
  slot_res_t  s2_q, s2_d;
  logic       out_valid_q, out_valid_d;
  out_beat_t  out_q, out_d;

  bucket_t    bucket;
  bucket_t    wr_bucket;
  entry_t     eval_slot;
  entry_t     new_entry;
  entry_t     hit_entry;
  slot_res_t  eval_res;
  logic       ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] item_idx;
  logic       accept, out_load, cfg_wr;
  logic       do_write, pick_slot2;

  assign ram_raddr = in_data_i.position_key[IDX_W-1:0] & IDX_MASK;
  assign item_idx  = item_q.position_key[IDX_W-1:0] & IDX_MASK;

  twtt_bucket_ram #(
    .DEPTH  (BUCKET_COUNT),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_bucket),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (bucket)
  );

  assign eval_slot = (state_q == ST_SLOT2) ? bucket.slot2 : bucket.slot1;

  twtt_slot_eval u_eval (
    .slot_i  (eval_slot),
    .key_i   (item_q.position_key),
    .depth_i (item_q.search_depth),
    .age_i   (age_q),
    .res_o   (eval_res)
  );

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr[2] == ADDR_AGE) ? 32'(age_q) : '0;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign ram_re      = accept;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign new_entry = '{
    key:   item_q.position_key,
    score: item_q.search_score,
    move:  item_q.best_move,
    eval:  item_q.static_eval,
    depth: item_q.search_depth,
    bound: item_q.bound_type,
    age:   age_q
  };

  always_comb begin
    if (s1_q.match) begin
      pick_slot2 = 1'b0;
      do_write   = 1'b1;
    end else if (s2_q.match) begin
      pick_slot2 = 1'b1;
      do_write   = 1'b1;
    end else begin
      pick_slot2 = (s1_q.value < s2_q.value);
      do_write   = (s1_q.value >= REPL_MIN) || (s2_q.value >= REPL_MIN);
    end
    do_write = do_write && (item_q.kind == KIND_STORE);
  end

  always_comb begin
    wr_bucket = bucket;
    if (state_q == ST_CLEAR) begin
      wr_bucket = '0;
    end else if (pick_slot2) begin
      wr_bucket.slot2 = new_entry;
    end else begin
      wr_bucket.slot1 = new_entry;
    end
  end

  assign ram_we    = (state_q == ST_CLEAR) || (out_load && do_write);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : item_idx;
  assign hit_entry = s1_q.match ? bucket.slot1 : bucket.slot2;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    age_d       = cfg_wr && (paddr[2] == ADDR_AGE) ? pwdata[5:0] : age_q;
    item_d      = accept ? in_data_i : item_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    out_valid_d = (out_valid_q && out_ready_i) ? 1'b0 : out_valid_q;
    out_d       = out_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(BUCKET_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SLOT1;
        end
      end
      ST_SLOT1: begin
        s1_d    = eval_res;
        state_d = ST_SLOT2;
      end
      ST_SLOT2: begin
        s2_d    = eval_res;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (item_q.kind == KIND_STORE) begin
            out_d.written = do_write;
          end else if (s1_q.match || s2_q.match) begin
            out_d.hit         = 1'b1;
            out_d.found_score = hit_entry.score;
            out_d.found_move  = hit_entry.move;
            out_d.found_eval  = hit_entry.eval;
            out_d.found_depth = hit_entry.depth;
            out_d.found_bound = hit_entry.bound;
            out_d.found_age   = hit_entry.age;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      age_q       <= '0;
      item_q      <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      age_q       <= age_d;
      item_q      <= item_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_hit_xor_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.written))
    else $error("hit and written both set");

  a_write_only_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != ST_CLEAR) |-> (out_load && item_q.kind == KIND_STORE))
    else $error("bucket write outside a store resolve");

  a_written_matches_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && item_q.kind == KIND_STORE) |=> (out_data_o.written == $past(ram_we)))
    else $error("written flag differs from bucket write");

  a_accept_to_slot1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SLOT1))
    else $error("accepted beat did not start evaluation");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> (state_q == ST_FIN))
    else $error("resolve left while result stalled");
`endif

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twtt_pkg::*;

  localparam int unsigned TT_BUCKETS = BUCKET_COUNT_DEF;
  localparam int unsigned TT_SLOTS = 2 * TT_BUCKETS;
  localparam logic [2:0] REG_CURRENT_AGE = 3'd0;
  localparam int AGE_WEIGHT = 16;
  localparam int PHASE_ITEMS = 54;
  localparam int HOLD_AT_BEAT = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  two_way_transposition_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the bucket ram and the age register
  entry_t      tt_mem [TT_SLOTS];
  logic [5:0]  tt_age = '0;

  in_beat_t    request_q [$];
  out_beat_t   pending_results [$];
  int          queued_count = 0;
  int          recv_count = 0;
  int          err_count = 0;
  int          n_probe = 0, n_hit = 0, n_store = 0, n_written = 0, n_refused = 0;
  int          n_cfg = 0;

  function automatic int repl_value(entry_t e, logic [7:0] depth);
    logic [5:0] age_diff;
    age_diff = tt_age - e.age;
    return AGE_WEIGHT * int'(age_diff) + int'(depth) - int'(e.depth);
  endfunction

  function automatic void tt_predict(input in_beat_t b, output out_beat_t r);
    int unsigned base;
    int unsigned slot;
    entry_t      s1, s2, m;
    int          v1, v2;
    bit          found;
    bit          do_write;
    base = 2 * int'(b.position_key & 64'(TT_BUCKETS - 1));
    s1 = tt_mem[base];
    s2 = tt_mem[base + 1];
    r = '0;
    found = 1'b0;
    m = '0;
    if (b.kind == KIND_PROBE) begin
      n_probe++;
      if (s1.key == b.position_key) begin
        m = s1;
        found = 1'b1;
      end else if (s2.key == b.position_key) begin
        m = s2;
        found = 1'b1;
      end
      if (found) begin
        n_hit++;
        r.hit = 1'b1;
        r.found_score = m.score;
        r.found_move = m.move;
        r.found_eval = m.eval;
        r.found_depth = m.depth;
        r.found_bound = m.bound;
        r.found_age = m.age;
      end
    end else begin
      n_store++;
      do_write = 1'b1;
      if (s1.key == b.position_key) begin
        slot = base;
      end else if (s2.key == b.position_key) begin
        slot = base + 1;
      end else begin
        v1 = repl_value(s1, b.search_depth);
        v2 = repl_value(s2, b.search_depth);
        slot = (v1 < v2) ? base + 1 : base;
        do_write = (v1 >= int'(REPL_MIN)) || (v2 >= int'(REPL_MIN));
      end
      if (do_write) begin
        n_written++;
        tt_mem[slot].key = b.position_key;
        tt_mem[slot].score = b.search_score;
        tt_mem[slot].move = b.best_move;
        tt_mem[slot].eval = b.static_eval;
        tt_mem[slot].depth = b.search_depth;
        tt_mem[slot].bound = b.bound_type;
        tt_mem[slot].age = tt_age;
        r.written = 1'b1;
      end else begin
        n_refused++;
      end
    end
  endfunction

  // request driver: bursts of random length with random gaps
  int  burst_left = 0;
  int  gap_left = 0;
  logic drv_fire;
  logic drv_next;
  out_beat_t drv_res;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      drv_fire = in_valid && in_ready;
      if (drv_fire) begin
        tt_predict(in_data, drv_res);
        pending_results.push_back(drv_res);
      end
      if (!in_valid || drv_fire) begin
        drv_next = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          drv_next = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
        in_valid <= drv_next;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      err_count++;
    end
  endtask

  // result monitor with its own stall pattern and one long hold-off
  int  rx_cyc = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic rx_next;
  out_beat_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_cyc = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        recv_count++;
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit", want.hit, out_data.hit);
          check_field("written", want.written, out_data.written);
          check_field("found_score", want.found_score, out_data.found_score);
          check_field("found_move", want.found_move, out_data.found_move);
          check_field("found_eval", want.found_eval, out_data.found_eval);
          check_field("found_depth", want.found_depth, out_data.found_depth);
          check_field("found_bound", want.found_bound, out_data.found_bound);
          check_field("found_age", want.found_age, out_data.found_age);
        end
      end
      rx_cyc++;
      if (!hold_done && recv_count == HOLD_AT_BEAT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_next = 1'b0;
      end else begin
        case (rx_cyc[8:7])
          2'd0: rx_next = 1'b1;
          2'd1: rx_next = ($urandom_range(0, 1) == 1);
          2'd2: rx_next = ($urandom_range(0, 3) == 0);
          default: rx_next = (rx_cyc[2:0] != 3'd0);
        endcase
      end
      out_ready <= rx_next;
    end
  end

  // key pool spread over a few buckets so that slots collide and age out
  logic [63:0] key_pool [32];
  logic [11:0] pool_bucket [8] = '{12'h000, 12'hfff, 12'h001, 12'h800,
                                   12'h555, 12'haaa, 12'h007, 12'h123};

  function automatic in_beat_t mk_item(logic kind, logic [63:0] key, logic [15:0] score,
                                       logic [15:0] move, logic [15:0] eval,
                                       logic [7:0] depth, logic [1:0] bound);
    in_beat_t b;
    b.kind = kind;
    b.position_key = key;
    b.search_score = score;
    b.best_move = move;
    b.static_eval = eval;
    b.search_depth = depth;
    b.bound_type = bound;
    return b;
  endfunction

  function automatic in_beat_t rand_item();
    logic [63:0] key;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      key = key_pool[$urandom_range(0, 31)];
    end else if (pick == 8) begin
      key = {$urandom, $urandom};
      key[11:0] = pool_bucket[$urandom_range(0, 7)];
    end else begin
      key = {$urandom, $urandom};
    end
    return mk_item($urandom_range(0, 1) ? KIND_STORE : KIND_PROBE, key,
                   16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
  endfunction

  task automatic queue_item(in_beat_t b);
    request_q.push_back(b);
    queued_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (recv_count != queued_count);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [5:0] age);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_CURRENT_AGE;
    pwdata <= 32'(age);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tt_age = age;
    n_cfg++;
  endtask

  initial begin
    logic [63:0] k_ones, ka, kb, kc, kd;
    logic [5:0]  ages [8];
    int          i, p;
    for (i = 0; i < TT_SLOTS; i++) tt_mem[i] = '0;
    for (i = 0; i < 32; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][11:0] = pool_bucket[i % 8];
    end
    ages[0] = 6'd63;
    ages[1] = 6'd62;
    ages[2] = 6'd0;
    ages[3] = 6'($urandom_range(0, 63));
    ages[4] = 6'd63;
    ages[5] = 6'd17;
    ages[6] = 6'($urandom_range(0, 63));
    ages[7] = 6'd40;
    k_ones = '1;
    ka = 64'h0123_4567_89ab_c123;
    kb = 64'hfedc_ba98_7654_3123;
    kc = 64'h5555_aaaa_5555_a123;
    kd = 64'haaaa_5555_aaaa_5123;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cleared entries answer to key zero
    queue_item(mk_item(KIND_PROBE, 64'd0, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_PROBE, k_ones, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_STORE, 64'd0, 16'h8000, 16'hffff, 16'h7fff, 8'd255, 2'd3));
    queue_item(mk_item(KIND_PROBE, 64'd0, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_STORE, k_ones, 16'h7fff, 16'h0000, 16'h8000, 8'd0, 2'd0));
    queue_item(mk_item(KIND_PROBE, k_ones, 16'hffff, 16'hffff, 16'hffff, 8'd255, 2'd3));
    // fill one bucket, then refuse, then accept at the threshold
    queue_item(mk_item(KIND_STORE, ka, 16'h1234, 16'h5678, 16'h9abc, 8'd200, 2'd2));
    queue_item(mk_item(KIND_STORE, kb, 16'h4321, 16'h8765, 16'hcba9, 8'd200, 2'd1));
    queue_item(mk_item(KIND_STORE, kc, 16'h1111, 16'h2222, 16'h3333, 8'd197, 2'd3));
    queue_item(mk_item(KIND_PROBE, kc, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_STORE, kd, 16'h4444, 16'h5555, 16'h6666, 8'd198, 2'd0));
    queue_item(mk_item(KIND_PROBE, ka, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_PROBE, kd, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_PROBE, kb, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    // slot two key match overwrites in place
    queue_item(mk_item(KIND_STORE, kb, 16'hfffe, 16'h0001, 16'h8001, 8'd5, 2'd1));
    queue_item(mk_item(KIND_PROBE, kb, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_PROBE, 64'h1000, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_STORE, 64'h1000, 16'h0042, 16'h0043, 16'h0044, 8'd0, 2'd2));
    queue_item(mk_item(KIND_PROBE, 64'h1000, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    queue_item(mk_item(KIND_PROBE, 64'd0, 16'h0, 16'h0, 16'h0, 8'd0, 2'd0));
    wait_drained();

    for (p = 0; p < 8; p++) begin
      cfg_write(ages[p]);
      for (i = 0; i < PHASE_ITEMS; i++) queue_item(rand_item());
      wait_drained();
    end

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_count++;
    end
    $display("covered %0d probes (%0d hits), %0d stores (%0d written, %0d refused)",
             n_probe, n_hit, n_store, n_written, n_refused);
    $display("over %0d age register writes with one long output hold-off", n_cfg);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
